/* hw/rtl/irpm_pkg.sv */
// ----------------------------------------------------------------------------
// irpm_pkg
// Types and fixed constants shared by the image RMSE / PSNR meter.
// ----------------------------------------------------------------------------
package irpm_pkg;

    typedef struct packed {
        logic [7:0] rendered_red;
        logic [7:0] rendered_green;
        logic [7:0] rendered_blue;
        logic [7:0] target_red;
        logic [7:0] target_green;
        logic [7:0] target_blue;
        logic       last_pixel;
    } pix_t;

    typedef struct packed {
        logic [15:0] luma_rmse;
        logic [15:0] color_rmse;
        logic [14:0] psnr_db;
        logic [22:0] pixel_total;
        logic        count_overflow;
    } res_t;

    // datapath commands from the controller
    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic div_color;
        logic sqrt_start;
        logic sqrt_color;
        logic log_start;
        logic psnr_mul;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic div_done;
        logic sqrt_done;
        logic log_done;
    } sts_t;

    localparam int LUMA_SUM_W  = 56;
    localparam int COLOR_SUM_W = 42;
    localparam int QUOT_W      = 58;
    localparam int ROOT_W      = QUOT_W / 2;
    localparam int LOG_ITERS   = 16;

    localparam logic [16:0] WEIGHT_R      = 17'd19595;
    localparam logic [16:0] WEIGHT_G      = 17'd38470;
    localparam logic [16:0] WEIGHT_B      = 17'd7471;
    localparam logic [18:0] PSNR_K        = 19'd394566;
    localparam logic [14:0] PSNR_NO_ERROR = 15'd25344;
    localparam logic [15:0] PEAK_Q8       = 16'd65280;

    // Q16 log2 by repeated squaring, used only at elaboration for the peak term
    function automatic logic [20:0] log2_q16(input logic [16:0] x);
        logic [4:0]  e;
        logic [15:0] frac;
        logic [63:0] m;
        e    = 5'd0;
        frac = 16'd0;
        for (int i = 1; i < 17; i++) begin
            if ((x >> i) != 17'd0) e = 5'(i);
        end
        m = 64'(x) << (30 - e);
        for (int i = 0; i < LOG_ITERS; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[15 - i] = 1'b1;
            end
        end
        return {e, frac};
    endfunction

    localparam logic [20:0] LOG2_PEAK = log2_q16({1'b0, PEAK_Q8});

endpackage

/* hw/rtl/irpm_ctrl.sv */
// ----------------------------------------------------------------------------
// irpm_ctrl
// Sequencer: accumulates pixels, then steps divider, root and log units.
// ----------------------------------------------------------------------------
module irpm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_last,
    output logic            m_valid,
    input  logic            m_ready,
    input  irpm_pkg::sts_t  sts,
    output irpm_pkg::cmd_t  cmd
);
    import irpm_pkg::*;

    localparam logic [3:0] ST_ACC   = 4'd0;
    localparam logic [3:0] ST_DRAIN = 4'd1;
    localparam logic [3:0] ST_DIVL  = 4'd2;
    localparam logic [3:0] ST_SQL   = 4'd3;
    localparam logic [3:0] ST_DIVC  = 4'd4;
    localparam logic [3:0] ST_SQC   = 4'd5;
    localparam logic [3:0] ST_LOG   = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_ACC);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_ACC: begin
                cmd.acc_en = s_valid;
                if (s_valid && s_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVL;
                end
            end
            ST_DIVL: begin
                if (sts.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQL;
                end
            end
            ST_SQL: begin
                if (sts.sqrt_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_color = 1'b1;
                    state_next    = ST_DIVC;
                end
            end
            ST_DIVC: begin
                if (sts.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    cmd.sqrt_color = 1'b1;
                    state_next     = ST_SQC;
                end
            end
            ST_SQC: begin
                if (sts.sqrt_done) begin
                    cmd.log_start = 1'b1;
                    state_next    = ST_LOG;
                end
            end
            ST_LOG: begin
                if (sts.log_done) begin
                    cmd.psnr_mul = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                // output register free or being emptied this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* hw/rtl/irpm_dp.sv */
// ----------------------------------------------------------------------------
// irpm_dp
// Datapath: error accumulation, shared divider, shared root, log2, PSNR.
// ----------------------------------------------------------------------------
module irpm_dp #(
    parameter int MAX_PIXELS_LOG2 = 22
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  irpm_pkg::pix_t  s_data,
    input  irpm_pkg::cmd_t  cmd,
    output irpm_pkg::sts_t  sts,
    output irpm_pkg::res_t  res_data
);
    import irpm_pkg::*;

    localparam int CW    = MAX_PIXELS_LOG2 + 1;
    localparam int DVW   = CW + 2;
    localparam int REMW  = DVW + 1;
    localparam int DCW   = $clog2(QUOT_W + 1);
    localparam int SCW   = $clog2(ROOT_W + 1);
    localparam int LCW   = $clog2(LOG_ITERS + 1);
    localparam int SREMW = ROOT_W + 2;
    localparam logic [CW-1:0] COUNT_FULL = CW'(1) << MAX_PIXELS_LOG2;

    // ---------------- accumulation ----------------
    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] drx, dgx, dbx;
    logic signed [26:0] d16;
    logic [25:0]        mag;
    logic [16:0]        d8;
    logic [17:0]        csq;

    assign dr  = $signed({1'b0, s_data.rendered_red})   - $signed({1'b0, s_data.target_red});
    assign dg  = $signed({1'b0, s_data.rendered_green}) - $signed({1'b0, s_data.target_green});
    assign db  = $signed({1'b0, s_data.rendered_blue})  - $signed({1'b0, s_data.target_blue});
    assign d16 = $signed({1'b0, WEIGHT_R}) * dr + $signed({1'b0, WEIGHT_G}) * dg
               + $signed({1'b0, WEIGHT_B}) * db;
    assign mag = d16[26] ? 26'(-d16) : 26'(d16);
    assign d8  = 17'(({1'b0, mag} + 27'd128) >> 8);
    assign drx = 18'(dr);
    assign dgx = 18'(dg);
    assign dbx = 18'(db);
    assign csq = 18'(drx * drx + dgx * dgx + dbx * dbx);

    logic [16:0]            d8_reg;
    logic [17:0]            csq_reg;
    logic                   stg_valid_reg;
    logic [LUMA_SUM_W-1:0]  luma_sum_reg;
    logic [COLOR_SUM_W-1:0] color_sum_reg;
    logic [CW-1:0]          count_reg;
    logic                   ovf_reg;
    logic [33:0]            lsq;
    logic [LUMA_SUM_W:0]    lsum;
    logic [COLOR_SUM_W:0]   csum;

    assign lsq  = d8_reg * d8_reg;
    assign lsum = {1'b0, luma_sum_reg} + (LUMA_SUM_W + 1)'(lsq);
    assign csum = {1'b0, color_sum_reg} + (COLOR_SUM_W + 1)'(csq_reg);

    always_ff @(posedge aclk) begin
        d8_reg  <= d8;
        csq_reg <= csq;
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            luma_sum_reg  <= '0;
            color_sum_reg <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end else if (cmd.out_load) begin
            stg_valid_reg <= 1'b0;
            luma_sum_reg  <= '0;
            color_sum_reg <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            stg_valid_reg <= cmd.acc_en && (count_reg != COUNT_FULL);
            if (cmd.acc_en) begin
                if (count_reg != COUNT_FULL) count_reg <= count_reg + CW'(1);
                else                         ovf_reg   <= 1'b1;
            end
            if (stg_valid_reg) begin
                luma_sum_reg  <= lsum[LUMA_SUM_W]  ? '1 : lsum[LUMA_SUM_W-1:0];
                color_sum_reg <= csum[COLOR_SUM_W] ? '1 : csum[COLOR_SUM_W-1:0];
            end
        end
    end

    // ---------------- restoring divider, one quotient bit per cycle ----------------
    logic [CW-1:0]     n_eff;
    logic [QUOT_W-1:0] dvd_reg;
    logic [DVW-1:0]    dvs_reg;
    logic [REMW-1:0]   rem_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic              div_run_reg;
    logic [REMW-1:0]   div_trial;
    logic              div_ge;

    assign n_eff     = (count_reg == '0) ? CW'(1) : count_reg;
    assign div_trial = {rem_reg[REMW-2:0], dvd_reg[QUOT_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_run_reg <= 1'b0;
        end else if (cmd.div_start) begin
            div_run_reg <= 1'b1;
        end else if (div_run_reg && div_cnt_reg == DCW'(1)) begin
            div_run_reg <= 1'b0;
        end
        if (cmd.div_start) begin
            dvd_reg     <= cmd.div_color ? {color_sum_reg, 16'd0} : QUOT_W'(luma_sum_reg);
            dvs_reg     <= cmd.div_color ? (DVW'({n_eff, 1'b0}) + DVW'(n_eff)) : DVW'(n_eff);
            rem_reg     <= '0;
            div_cnt_reg <= DCW'(QUOT_W);
        end else if (div_run_reg) begin
            rem_reg     <= div_ge ? (div_trial - {1'b0, dvs_reg}) : div_trial;
            dvd_reg     <= {dvd_reg[QUOT_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    // ---------------- integer root, one result bit per cycle ----------------
    logic [QUOT_W-1:0] sq_src_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SREMW-1:0]  srem_reg;
    logic [SCW-1:0]    sq_cnt_reg;
    logic              sq_run_reg;
    logic              sq_fin_reg;
    logic              sq_color_reg;
    logic [SREMW+1:0]  sq_cur;
    logic [SREMW+1:0]  sq_trial;
    logic              sq_ge;
    logic              sq_up;
    logic [ROOT_W:0]   root_rnd;
    logic [15:0]       root_sat;
    logic [15:0]       lrm_reg;
    logic [15:0]       crm_reg;

    assign sq_cur   = {srem_reg, sq_src_reg[QUOT_W-1 -: 2]};
    assign sq_trial = (SREMW + 2)'({root_reg, 2'b01});
    assign sq_ge    = (sq_cur >= sq_trial);
    // round up when the remainder exceeds the root
    assign sq_up    = (srem_reg > SREMW'(root_reg));
    assign root_rnd = (ROOT_W + 1)'(root_reg) + (ROOT_W + 1)'(sq_up);
    assign root_sat = (root_rnd > (ROOT_W + 1)'(16'hFFFF)) ? 16'hFFFF : root_rnd[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_run_reg <= 1'b0;
            sq_fin_reg <= 1'b0;
        end else begin
            sq_fin_reg <= sq_run_reg && sq_cnt_reg == SCW'(1);
            if (cmd.sqrt_start) begin
                sq_run_reg <= 1'b1;
            end else if (sq_run_reg && sq_cnt_reg == SCW'(1)) begin
                sq_run_reg <= 1'b0;
            end
        end
        if (cmd.sqrt_start) begin
            sq_src_reg   <= dvd_reg;
            root_reg     <= '0;
            srem_reg     <= '0;
            sq_cnt_reg   <= SCW'(ROOT_W);
            sq_color_reg <= cmd.sqrt_color;
        end else if (sq_run_reg) begin
            srem_reg   <= sq_ge ? SREMW'(sq_cur - sq_trial) : SREMW'(sq_cur);
            root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
            sq_src_reg <= sq_src_reg << 2;
            sq_cnt_reg <= sq_cnt_reg - SCW'(1);
        end
        if (sq_fin_reg) begin
            if (sq_color_reg) crm_reg <= root_sat;
            else              lrm_reg <= root_sat;
        end
    end

    // ---------------- log2 by repeated squaring ----------------
    logic [3:0]     lead;
    logic [30:0]    m_reg;
    logic [15:0]    frac_reg;
    logic [3:0]     e_reg;
    logic [LCW-1:0] log_cnt_reg;
    logic           log_run_reg;
    logic [61:0]    m_sq;

    always_comb begin
        lead = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (lrm_reg[i]) lead = 4'(i);
        end
    end

    assign m_sq = m_reg * m_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_run_reg <= 1'b0;
        end else if (cmd.log_start) begin
            log_run_reg <= 1'b1;
        end else if (log_run_reg && log_cnt_reg == LCW'(1)) begin
            log_run_reg <= 1'b0;
        end
        if (cmd.log_start) begin
            e_reg       <= lead;
            m_reg       <= 31'({15'd0, lrm_reg} << (5'd30 - {1'b0, lead}));
            frac_reg    <= '0;
            log_cnt_reg <= LCW'(LOG_ITERS);
        end else if (log_run_reg) begin
            m_reg       <= m_sq[61] ? m_sq[61:31] : m_sq[60:30];
            frac_reg    <= {frac_reg[14:0], m_sq[61]};
            log_cnt_reg <= log_cnt_reg - LCW'(1);
        end
    end

    // ---------------- PSNR scaling ----------------
    logic [20:0] log_bot;
    logic [20:0] log_diff;
    logic [39:0] prod_reg;
    logic [40:0] prod_rnd;
    logic [16:0] psnr_raw;
    logic [14:0] psnr;

    assign log_bot  = {1'b0, e_reg, frac_reg};
    assign log_diff = (LOG2_PEAK > log_bot) ? (LOG2_PEAK - log_bot) : 21'd0;
    assign prod_rnd = {1'b0, prod_reg} + (41'd1 << 23);
    assign psnr_raw = prod_rnd[40:24];
    assign psnr     = (lrm_reg == 16'd0 || psnr_raw > 17'(PSNR_NO_ERROR))
                    ? PSNR_NO_ERROR : psnr_raw[14:0];

    always_ff @(posedge aclk) begin
        if (cmd.psnr_mul) prod_reg <= log_diff * PSNR_K;
        if (cmd.out_load) begin
            res_data.luma_rmse      <= lrm_reg;
            res_data.color_rmse     <= crm_reg;
            res_data.psnr_db        <= psnr;
            res_data.pixel_total    <= 23'(count_reg);
            res_data.count_overflow <= ovf_reg;
        end
    end

    assign sts.pipe_busy = stg_valid_reg;
    assign sts.div_done  = !div_run_reg;
    assign sts.sqrt_done = !sq_run_reg && !sq_fin_reg;
    assign sts.log_done  = !log_run_reg;

endmodule

/* hw/rtl/image_rmse_psnr_meter.sv */
// ----------------------------------------------------------------------------
// image_rmse_psnr_meter
// Luma / color RMSE and luma PSNR over a stream of rendered/reference pixels.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while an image streams in.
// After the last pixel, the sequencer lets the accumulator drain, then runs two
// 58-bit passes of the shared bit-serial divider, two 29-bit passes of the shared
// root unit, 16 log2 squaring steps and the PSNR scaling. No pixel is taken until
// the result is loaded. Reset (aresetn, synchronous, active low) clears the
// sequencer and the output valid; sums and the pixel count are zeroed.
module image_rmse_psnr_meter #(
    parameter int MAX_PIXELS_LOG2 = 22
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  irpm_pkg::pix_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output irpm_pkg::res_t  m_data
);
    import irpm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    irpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_data.last_pixel),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    irpm_dp #(
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .res_data (m_data)
    );

    // a last pixel closes the image: no pixel is taken in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_pixel |=> !s_ready)
        else $error("pixel accepted right after last pixel");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.luma_rmse == 16'd0 |-> m_data.psnr_db == PSNR_NO_ERROR)
        else $error("zero luma error without no-error PSNR");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.psnr_db <= PSNR_NO_ERROR)
        else $error("PSNR above clamp");

    // a result is loaded only when the sequencer has finished all units
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.div_done && sts.sqrt_done && sts.log_done)
        else $error("result loaded while a unit is busy");

endmodule

/* dv/tb_image_rmse_psnr_meter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_rmse_psnr_meter
// Streams rendered/reference pixel pairs into the meter and compares each
// image result with a bit-accurate fixed-point prediction.
// ----------------------------------------------------------------------------
module tb_image_rmse_psnr_meter;
    import irpm_pkg::*;

    localparam int MAXPIX_LOG2 = 22;
    localparam int N_RANDOM    = 550;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    pix_t   s_data = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    res_t   m_data;

    always #5 aclk = ~aclk;

    image_rmse_psnr_meter #(.MAX_PIXELS_LOG2(MAXPIX_LOG2)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // prediction state
    logic [55:0] luma_acc;
    logic [41:0] color_acc;
    logic [22:0] pix_cnt;
    logic        ovf_seen;
    res_t        expected_results[$];
    int          n_errors = 0;
    bit          quiet = 1'b0;

    function automatic logic [15:0] isqrt_round(input logic [63:0] q);
        logic [63:0] r, b, v;
        r = 0;
        b = 64'd1 << 62;
        v = q;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (q > r * r + r) r = r + 1;
        if (r > 64'hFFFF) r = 64'hFFFF;
        return r[15:0];
    endfunction

    function automatic logic [20:0] log2_fix(input logic [16:0] x);
        int unsigned e;
        logic [15:0] frac;
        logic [63:0] m;
        e = 0;
        frac = 0;
        while (e < 31 && (x >> (e + 1)) != 0) e++;
        m = 64'(x) << (30 - e);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[15 - i] = 1'b1;
            end
        end
        return {e[4:0], frac};
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] lim);
        if (a > lim || b > lim - a) return lim;
        return a + b;
    endfunction

    function automatic void clear_image();
        luma_acc  = 0;
        color_acc = 0;
        pix_cnt   = 0;
        ovf_seen  = 0;
    endfunction

    // update the accumulators; returns 1 with the image result on the last pixel
    function automatic bit predict_pixel(input pix_t p, output res_t r);
        longint dr, dg, db, d16, mag, d8, csq, n;
        logic [31:0] top, bot;
        logic [63:0] diff, ps;
        dr = longint'(p.rendered_red) - longint'(p.target_red);
        dg = longint'(p.rendered_green) - longint'(p.target_green);
        db = longint'(p.rendered_blue) - longint'(p.target_blue);
        r = '0;
        if (pix_cnt < (23'd1 << MAXPIX_LOG2)) begin
            d16 = 19595 * dr + 38470 * dg + 7471 * db;
            mag = d16 < 0 ? -d16 : d16;
            d8  = (mag + 128) >>> 8;
            csq = dr * dr + dg * dg + db * db;
            luma_acc  = sat_sum(luma_acc, d8 * d8, (64'd1 << 56) - 1);
            color_acc = sat_sum(color_acc, csq, (64'd1 << 42) - 1);
            pix_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (!p.last_pixel) return 0;
        n = pix_cnt == 0 ? 1 : pix_cnt;
        r.luma_rmse  = isqrt_round(64'(luma_acc) / n);
        r.color_rmse = isqrt_round((64'(color_acc) << 16) / (3 * n));
        if (r.luma_rmse == 0) begin
            r.psnr_db = PSNR_NO_ERROR;
        end else begin
            top  = log2_fix(17'd65280);
            bot  = log2_fix({1'b0, r.luma_rmse});
            diff = top > bot ? 64'(top - bot) : 64'd0;
            ps   = (diff * 394566 + (64'd1 << 23)) >> 24;
            r.psnr_db = ps > 25344 ? PSNR_NO_ERROR : ps[14:0];
        end
        r.pixel_total    = pix_cnt;
        r.count_overflow = ovf_seen;
        clear_image();
        return 1;
    endfunction

    // directed rows: pixel, whether the result is typed in, typed result
    typedef struct {
        pix_t p;
        bit   fixed;
        res_t r;
    } row_t;
    row_t dir_rows[$];

    function automatic pix_t mk(input logic [7:0] a, b, c, d, e, f, input logic l);
        pix_t p;
        p = {a, b, c, d, e, f, l};
        return p;
    endfunction

    function automatic pix_t rand_pix(input bit l);
        pix_t p;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        p = raw[$bits(pix_t)-1:0];
        p.last_pixel = l;
        return p;
    endfunction

    task automatic send(input pix_t p);
        res_t r;
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        if (predict_pixel(p, r)) expected_results.push_back(r);
        if (!quiet && ($urandom_range(99) < 8)) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && !quiet) m_ready <= ($urandom_range(99) >= 8);
        else m_ready <= 1'b1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", m_data);
            end else begin
                res_t e;
                e = expected_results.pop_front();
                if (m_data !== e) begin
                    n_errors++;
                    if (n_errors <= 10) $display("mismatch: expected %p, got %p", e, m_data);
                end
            end
        end
    end

    initial begin
        res_t z;
        z = '0;
        clear_image();
        // single-pixel images with results read off at a glance
        z.psnr_db = PSNR_NO_ERROR; z.pixel_total = 1;
        dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 1), 1, z});
        dir_rows.push_back('{mk(255, 255, 255, 255, 255, 255, 1), 1, z});
        z.luma_rmse = 16'd65280; z.color_rmse = 16'd65280; z.psnr_db = 0;
        dir_rows.push_back('{mk(255, 255, 255, 0, 0, 0, 1), 1, z});
        dir_rows.push_back('{mk(0, 0, 0, 255, 255, 255, 1), 1, z});
        // single channel extremes and unit differences, then two small images with mixed signs
        dir_rows.push_back('{mk(255, 0, 0, 0, 0, 0, 1), 0, z});
        dir_rows.push_back('{mk(0, 255, 0, 0, 0, 0, 1), 0, z});
        dir_rows.push_back('{mk(0, 0, 255, 0, 0, 0, 1), 0, z});
        dir_rows.push_back('{mk(0, 0, 0, 0, 0, 1, 1), 0, z});
        dir_rows.push_back('{mk(1, 0, 0, 0, 0, 0, 1), 0, z});
        dir_rows.push_back('{mk(170, 85, 15, 85, 170, 240, 0), 0, z});
        dir_rows.push_back('{mk(85, 170, 240, 170, 85, 15, 0), 0, z});
        dir_rows.push_back('{mk(128, 127, 1, 127, 128, 254, 1), 0, z});
        dir_rows.push_back('{mk(10, 20, 30, 12, 18, 31, 0), 0, z});
        dir_rows.push_back('{mk(10, 20, 30, 10, 20, 30, 1), 0, z});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send(dir_rows[i].p);
            if (dir_rows[i].fixed && expected_results.size() > 0) begin
                // typed value replaces the prediction for this row
                if (expected_results[$] !== dir_rows[i].r) begin
                    n_errors++;
                    if (n_errors <= 10) $display("predictor disagrees on row %0d", i);
                end
                expected_results[$] = dir_rows[i].r;
            end
        end

        // hold the sender until every result is back
        s_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge aclk);

        // random images of mostly small size; one stretch with no idling
        for (int k = 0; k < N_RANDOM; ) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            quiet = (k > 250 && k < 350);
            for (int j = 0; j < len; j++) begin
                pix_t p;
                if ($urandom_range(3) == 0) begin
                    p = rand_pix(j == len - 1);
                end else begin
                    // small differences give useful PSNR values
                    p = rand_pix(j == len - 1);
                    p.target_red   = p.rendered_red ^ 8'($urandom_range(3));
                    p.target_green = p.rendered_green ^ 8'($urandom_range(3));
                    p.target_blue  = p.rendered_blue ^ 8'($urandom_range(3));
                end
                send(p);
                k++;
            end
        end
        quiet = 1'b0;
        s_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (300) @(posedge aclk);
        if (n_errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
